FILE: design/jssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssc_pkg
// Shared types, codes and literal tables for the JSON stream syntax checker.
// ----------------------------------------------------------------------------
package jssc_pkg;

   localparam int DefStackDepth = 64;
   localparam logic [6:0] DefDepthLimit = 7'd64;

   localparam logic [1:0] EV_TEXT   = 2'd0;
   localparam logic [1:0] EV_TOKEN  = 2'd1;
   localparam logic [1:0] EV_FAULT  = 2'd2;
   localparam logic [1:0] EV_ACCEPT = 2'd3;

   localparam logic [3:0] TK_OBJ_OPEN  = 4'd0;
   localparam logic [3:0] TK_OBJ_CLOSE = 4'd1;
   localparam logic [3:0] TK_ARR_OPEN  = 4'd2;
   localparam logic [3:0] TK_ARR_CLOSE = 4'd3;
   localparam logic [3:0] TK_KEY       = 4'd4;
   localparam logic [3:0] TK_STRING    = 4'd5;
   localparam logic [3:0] TK_INT       = 4'd6;
   localparam logic [3:0] TK_FRAC      = 4'd7;
   localparam logic [3:0] TK_TRUE      = 4'd8;

   localparam logic [3:0] FC_BAD_TOKEN   = 4'd0;
   localparam logic [3:0] FC_VALUE_EXP   = 4'd1;
   localparam logic [3:0] FC_BAD_KEY     = 4'd2;
   localparam logic [3:0] FC_NO_COLON    = 4'd3;
   localparam logic [3:0] FC_NO_COMMA_BR = 4'd4;
   localparam logic [3:0] FC_NO_COMMA_BK = 4'd5;
   localparam logic [3:0] FC_BAD_ESCAPE  = 4'd6;
   localparam logic [3:0] FC_RAW_NEWLINE = 4'd7;
   localparam logic [3:0] FC_TOO_DEEP    = 4'd8;
   localparam logic [3:0] FC_TRAILING    = 4'd9;
   localparam logic [3:0] FC_EARLY_END   = 4'd10;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_LO_E   = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_LO_T   = 8'h74;
   localparam logic [7:0] CH_LO_F   = 8'h66;
   localparam logic [7:0] CH_LO_N   = 8'h6E;
   localparam logic [7:0] CH_LO_B   = 8'h62;
   localparam logic [7:0] CH_LO_R   = 8'h72;
   localparam logic [7:0] CH_LO_U   = 8'h75;

   typedef enum logic [9:0] {
      M_VALUE     = 10'b00_0000_0001,
      M_OBJ_FIRST = 10'b00_0000_0010,
      M_ARR_FIRST = 10'b00_0000_0100,
      M_KEY       = 10'b00_0000_1000,
      M_KEYSTR    = 10'b00_0001_0000,
      M_STRING    = 10'b00_0010_0000,
      M_COLON     = 10'b00_0100_0000,
      M_NUMBER    = 10'b00_1000_0000,
      M_AFTER     = 10'b01_0000_0000,
      M_LIT       = 10'b10_0000_0000
   } mode_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] tok;
      logic [7:0] text;
      logic [6:0] nest;
      logic [3:0] code;
      logic       last;
   } event_type;

   function automatic logic [7:0] lit_char(input logic [1:0] idx, input logic [2:0] pos);
      logic [7:0] ch;
      ch = CH_NUL;
      unique case (idx)
         2'd0: begin
            unique case (pos)
               3'd0: ch = 8'h72;
               3'd1: ch = 8'h75;
               3'd2: ch = 8'h65;
               default: ch = CH_NUL;
            endcase
         end
         2'd1: begin
            unique case (pos)
               3'd0: ch = 8'h61;
               3'd1: ch = 8'h6C;
               3'd2: ch = 8'h73;
               3'd3: ch = 8'h65;
               default: ch = CH_NUL;
            endcase
         end
         default: begin
            unique case (pos)
               3'd0: ch = 8'h69;
               3'd1: ch = 8'h6C;
               default: ch = CH_NUL;
            endcase
         end
      endcase
      return ch;
   endfunction

   function automatic logic [2:0] lit_len(input logic [1:0] idx);
      logic [2:0] n;
      unique case (idx)
         2'd0: n = 3'd3;
         2'd1: n = 3'd4;
         default: n = 3'd2;
      endcase
      return n;
   endfunction

endpackage

FILE: design/json_stream_syntax_checker.sv
`timescale 1ns / 1ps
// Results of a byte are registered and appear in the cycle after it is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and
// the receiver does not stall; a byte causing more results stalls the input
// while the result queue drains and while the receiver stalls.
// Reset: synchronous, active high; clears the document state, the result
// queue and sets depth_limit to 64. The container stack needs no clearing.
// ----------------------------------------------------------------------------
// json_stream_syntax_checker
// Byte-serial syntax checker with a container stack in a memory and a
// three-entry result queue.
// ----------------------------------------------------------------------------
module json_stream_syntax_checker #(
   parameter int STACK_DEPTH = jssc_pkg::DefStackDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic [6:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_doc,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [3:0] rsp_token_kind,
   output logic [7:0] rsp_text_byte,
   output logic [6:0] rsp_nest_level,
   output logic [3:0] rsp_fault_code,
   output logic       rsp_last_of_run
);
   import jssc_pkg::*;

   localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int LW = ((CW > 7) ? CW : 7) + 1;
   localparam logic [CW-1:0] SdCount = CW'(STACK_DEPTH);

   logic [6:0]    limit_ff;
   mode_type      mode_ff, mode_in, mode_eff;
   logic [CW-1:0] count_ff, count_in, cnt_push, cnt_pop;
   logic          top_ff, below_ff;
   logic [2:0]    lit_pos_ff, lit_pos_in;
   logic [2:0]    phase_ff, phase_in;
   logic          point_ff, point_in;
   logic          esc_ff, esc_in;
   logic          fault_ff, fault_in;
   logic          stack_mem [STACK_DEPTH];

   event_type     q_ff [3];
   logic [1:0]    qn_ff;
   event_type     cand [4];
   logic [3:0]    cand_v;
   event_type     slots [3];
   logic [1:0]    nslots;

   logic          take, drain, push, pop, push_kind, room;
   logic          blank, digit, num_cont, too_deep;
   logic [7:0]    c;
   logic [1:0]    lit_idx;
   logic [LW-1:0] lim, lim_reg, lim_sd, need;
   logic [IW-1:0] wr_idx, rd_idx;

   assign c       = req_data_byte;
   assign drain   = rsp_valid && !rsp_stall;
   assign req_stall = !((qn_ff == 2'd0) || ((qn_ff == 2'd1) && !rsp_stall));
   assign take    = req_valid && !req_stall;
   assign blank   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
   assign digit   = (c >= CH_0) && (c <= CH_9);
   assign room    = count_ff < SdCount;
   assign cnt_push = room ? count_ff + CW'(1) : count_ff;
   assign cnt_pop = count_ff - CW'(1);
   assign wr_idx  = count_ff[IW-1:0];
   assign rd_idx  = cnt_pop[IW-1:0] - IW'(2);
   assign lim_reg = LW'(limit_ff);
   assign lim_sd  = LW'(STACK_DEPTH);
   assign lim     = (lim_reg > lim_sd) ? lim_sd : lim_reg;
   assign need    = LW'(count_ff) + LW'(1);
   assign too_deep = need > lim;
   assign lit_idx = (phase_ff > 3'd2) ? 2'd2 : phase_ff[1:0];
   assign num_cont = digit
      || ((phase_ff == 3'd0) && (c == CH_POINT))
      || ((phase_ff <= 3'd1) && ((c == CH_LO_E) || (c == CH_UP_E)))
      || ((phase_ff == 3'd2) && ((c == CH_PLUS) || (c == CH_MINUS)));

   always_comb begin
      mode_in    = mode_ff;
      mode_eff   = mode_ff;
      count_in   = count_ff;
      lit_pos_in = lit_pos_ff;
      phase_in   = phase_ff;
      point_in   = point_ff;
      esc_in     = esc_ff;
      fault_in   = fault_ff;
      push       = 1'b0;
      push_kind  = 1'b0;
      pop        = 1'b0;
      cand_v     = '0;
      for (int i = 0; i < 4; i++) begin
         cand[i] = '0;
      end
      if (take && !fault_ff) begin
         priority if (mode_ff == M_ARR_FIRST && !blank && c != CH_RBRACK) begin
            mode_eff = M_VALUE;
         end else if (mode_ff == M_OBJ_FIRST && c != CH_RBRACE) begin
            mode_eff = M_KEY;
         end else if (mode_ff == M_NUMBER && !num_cont) begin
            cand_v[0]    = 1'b1;
            cand[0].kind = EV_TOKEN;
            cand[0].tok  = point_ff ? TK_FRAC : TK_INT;
            cand[0].nest = 7'(count_ff);
            mode_eff     = M_AFTER;
         end else begin
            mode_eff = mode_ff;
         end
         mode_in      = mode_eff;
         cand[1].nest = 7'(count_ff);
         unique case (mode_eff)
            M_VALUE: begin
               priority if (too_deep) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_TOO_DEEP;
                  fault_in = 1'b1;
               end else if (blank) begin
                  mode_in = M_VALUE;
               end else if (c == CH_LBRACE || c == CH_LBRACK) begin
                  push = 1'b1; push_kind = (c == CH_LBRACK);
                  count_in = cnt_push;
                  cand_v[1] = 1'b1; cand[1].kind = EV_TOKEN;
                  cand[1].tok = push_kind ? TK_ARR_OPEN : TK_OBJ_OPEN;
                  cand[1].nest = 7'(cnt_push);
                  mode_in = push_kind ? M_ARR_FIRST : M_OBJ_FIRST;
               end else if (c == CH_QUOTE) begin
                  mode_in = M_STRING; esc_in = 1'b0;
               end else if (digit) begin
                  mode_in = M_NUMBER; phase_in = 3'd0; point_in = 1'b0;
               end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
                  mode_in = M_LIT; lit_pos_in = 3'd0;
                  phase_in = (c == CH_LO_T) ? 3'd0 : (c == CH_LO_F) ? 3'd1 : 3'd2;
               end else if (c == CH_RBRACE || c == CH_RBRACK || c == CH_COMMA
                            || c == CH_COLON || c == CH_NUL) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_VALUE_EXP;
                  fault_in = 1'b1;
               end else begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_BAD_TOKEN;
                  fault_in = 1'b1;
               end
            end
            M_OBJ_FIRST, M_ARR_FIRST: begin
               if (!blank) begin
                  pop = 1'b1; count_in = cnt_pop;
                  cand_v[1] = 1'b1; cand[1].kind = EV_TOKEN;
                  cand[1].tok = top_ff ? TK_ARR_CLOSE : TK_OBJ_CLOSE;
                  cand[1].nest = 7'(cnt_pop);
                  mode_in = M_AFTER;
               end
            end
            M_KEY: begin
               if (c == CH_QUOTE) begin
                  mode_in = M_KEYSTR; esc_in = 1'b0;
               end else if (!blank) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_BAD_KEY;
                  fault_in = 1'b1;
               end
            end
            M_KEYSTR, M_STRING: begin
               priority if (esc_ff) begin
                  esc_in = 1'b0;
                  cand_v[1] = 1'b1; cand[1].kind = EV_TEXT;
                  priority if (c == CH_QUOTE || c == CH_SLASH || c == CH_BSLASH) begin
                     cand[1].text = c;
                  end else if (c == CH_LO_B) begin
                     cand[1].text = 8'h08;
                  end else if (c == CH_LO_F) begin
                     cand[1].text = 8'h0C;
                  end else if (c == CH_LO_N) begin
                     cand[1].text = CH_LF;
                  end else if (c == CH_LO_R) begin
                     cand[1].text = CH_CR;
                  end else if (c == CH_LO_T) begin
                     cand[1].text = CH_TAB;
                  end else if (c == CH_LO_U) begin
                     cand_v[1] = 1'b0;
                  end else begin
                     cand[1].kind = EV_FAULT; cand[1].code = FC_BAD_ESCAPE;
                     fault_in = 1'b1;
                  end
               end else if (c == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else if (c == CH_QUOTE) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_TOKEN;
                  cand[1].tok = (mode_eff == M_KEYSTR) ? TK_KEY : TK_STRING;
                  mode_in = (mode_eff == M_KEYSTR) ? M_COLON : M_AFTER;
               end else if (c == CH_LF || c == CH_CR) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_RAW_NEWLINE;
                  fault_in = 1'b1;
               end else begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_TEXT; cand[1].text = c;
               end
            end
            M_COLON: begin
               if (c == CH_COLON) begin
                  mode_in = M_VALUE;
               end else if (!blank) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_NO_COLON;
                  fault_in = 1'b1;
               end
            end
            M_NUMBER: begin
               priority if (digit) begin
                  if (phase_ff == 3'd2) phase_in = 3'd3;
               end else if (c == CH_POINT) begin
                  point_in = 1'b1; phase_in = 3'd1;
               end else if (c == CH_LO_E || c == CH_UP_E) begin
                  phase_in = 3'd2;
               end else begin
                  phase_in = 3'd3;
               end
            end
            M_LIT: begin
               if (lit_pos_ff >= lit_len(lit_idx) || c != lit_char(lit_idx, lit_pos_ff)) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_BAD_TOKEN;
                  fault_in = 1'b1;
               end else if (lit_pos_ff + 3'd1 == lit_len(lit_idx)) begin
                  lit_pos_in = 3'd0; phase_in = 3'd0;
                  cand_v[1] = 1'b1; cand[1].kind = EV_TOKEN;
                  cand[1].tok = TK_TRUE + 4'(lit_idx);
                  mode_in = M_AFTER;
               end else begin
                  lit_pos_in = lit_pos_ff + 3'd1;
               end
            end
            M_AFTER: begin
               priority if (count_ff == '0) begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT; cand[1].code = FC_TRAILING;
                  fault_in = 1'b1;
               end else if (blank) begin
                  mode_in = M_AFTER;
               end else if (c == CH_COMMA) begin
                  mode_in = top_ff ? M_VALUE : M_KEY;
               end else if ((top_ff && c == CH_RBRACK) || (!top_ff && c == CH_RBRACE)) begin
                  pop = 1'b1; count_in = cnt_pop;
                  cand_v[1] = 1'b1; cand[1].kind = EV_TOKEN;
                  cand[1].tok = top_ff ? TK_ARR_CLOSE : TK_OBJ_CLOSE;
                  cand[1].nest = 7'(cnt_pop);
               end else begin
                  cand_v[1] = 1'b1; cand[1].kind = EV_FAULT;
                  cand[1].code = top_ff ? FC_NO_COMMA_BK : FC_NO_COMMA_BR;
                  fault_in = 1'b1;
               end
            end
            default: mode_in = mode_eff;
         endcase
      end
      if (take && req_end_of_doc) begin
         if (!fault_in) begin
            if (mode_in == M_NUMBER) begin
               cand_v[2] = 1'b1; cand[2].kind = EV_TOKEN;
               cand[2].tok = point_in ? TK_FRAC : TK_INT;
               cand[2].nest = 7'(count_in);
            end
            cand_v[3] = 1'b1;
            cand[3].nest = 7'(count_in);
            if ((mode_in == M_NUMBER || mode_in == M_AFTER) && count_in == '0) begin
               cand[3].kind = EV_ACCEPT;
            end else begin
               cand[3].kind = EV_FAULT; cand[3].code = FC_EARLY_END;
            end
         end
         mode_in = M_VALUE; count_in = '0; lit_pos_in = 3'd0; phase_in = 3'd0;
         point_in = 1'b0; esc_in = 1'b0; fault_in = 1'b0;
      end
   end

   always_comb begin
      nslots = 2'd0;
      for (int i = 0; i < 3; i++) begin
         slots[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i] && nslots != 2'd3) begin
            slots[nslots] = cand[i];
            nslots = nslots + 2'd1;
         end
      end
      if (nslots != 2'd0) begin
         slots[nslots - 2'd1].last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= DefDepthLimit;
         mode_ff    <= M_VALUE;
         count_ff   <= '0;
         lit_pos_ff <= 3'd0;
         phase_ff   <= 3'd0;
         point_ff   <= 1'b0;
         esc_ff     <= 1'b0;
         fault_ff   <= 1'b0;
         qn_ff      <= 2'd0;
      end else begin
         if (csr_write_enable) limit_ff <= csr_write_data;
         if (take) begin
            mode_ff    <= mode_in;
            count_ff   <= count_in;
            lit_pos_ff <= lit_pos_in;
            phase_ff   <= phase_in;
            point_ff   <= point_in;
            esc_ff     <= esc_in;
            fault_ff   <= fault_in;
            qn_ff      <= nslots;
         end else if (drain) begin
            qn_ff <= qn_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         q_ff <= slots;
      end else if (drain) begin
         q_ff[0] <= q_ff[1];
         q_ff[1] <= q_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (push && room) begin
         stack_mem[wr_idx] <= push_kind;
         top_ff   <= push_kind;
         below_ff <= top_ff;
      end else if (pop) begin
         top_ff   <= below_ff;
         below_ff <= stack_mem[rd_idx];
      end
   end

   assign rsp_valid       = qn_ff != 2'd0;
   assign rsp_event_kind  = q_ff[0].kind;
   assign rsp_token_kind  = q_ff[0].tok;
   assign rsp_text_byte   = q_ff[0].text;
   assign rsp_nest_level  = q_ff[0].nest;
   assign rsp_fault_code  = q_ff[0].code;
   assign rsp_last_of_run = q_ff[0].last;

endmodule

FILE: design/jssc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jssc_checker
// Port-level checks on the result channel of the syntax checker.
// ----------------------------------------------------------------------------
module jssc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_kind,
   input logic [3:0] rsp_token_kind,
   input logic [7:0] rsp_text_byte,
   input logic [6:0] rsp_nest_level,
   input logic [3:0] rsp_fault_code,
   input logic       rsp_last_of_run
);
   import jssc_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("run of results broken");

   a_accept_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_ACCEPT |-> rsp_nest_level == 7'd0 && rsp_last_of_run)
      else $error("bad accept transaction");

   a_fault_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_FAULT |-> rsp_token_kind == 4'd0
      && rsp_text_byte == 8'd0 && rsp_last_of_run)
      else $error("bad fault transaction");

   a_text_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_TEXT |-> rsp_token_kind == 4'd0
      && rsp_fault_code == 4'd0)
      else $error("bad text transaction");

endmodule

bind json_stream_syntax_checker jssc_checker u_jssc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_kind  (rsp_event_kind),
   .rsp_token_kind  (rsp_token_kind),
   .rsp_text_byte   (rsp_text_byte),
   .rsp_nest_level  (rsp_nest_level),
   .rsp_fault_code  (rsp_fault_code),
   .rsp_last_of_run (rsp_last_of_run)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON stream syntax checker: generated documents,
// clean and broken, stream through the byte port under random idling on both
// sides, and every event is compared field by field with a built-in parser.
// ----------------------------------------------------------------------------
module tb;
   import jssc_pkg::*;

   localparam logic [3:0] TK_FALSE = 4'd9;
   localparam logic [3:0] TK_NIL   = 4'd10;
   localparam int NestCap = 64;

   class doc_scoreboard;
      logic [6:0] limit_reg;
      mode_type   mode;
      bit         kinds[NestCap];
      int         opens;
      int         lit_pos;
      int         lit_idx;
      int         num_phase;
      bit         has_point;
      bit         esc;
      bit         faulted;
      event_type  events_due[$];
      event_type  step_events[$];
      int         errors;
      int         events_checked;
      string      lit_words[3];

      function new();
         limit_reg = DefDepthLimit;
         lit_words = '{"rue", "alse", "il"};
         clear_doc();
      endfunction

      function void clear_doc();
         mode = M_VALUE;
         opens = 0;
         lit_pos = 0;
         lit_idx = 0;
         num_phase = 0;
         has_point = 0;
         esc = 0;
         faulted = 0;
      endfunction

      function int pending();
         return events_due.size();
      endfunction

      function void emit(logic [1:0] kind, logic [3:0] tok, logic [7:0] text,
                         logic [3:0] code);
         event_type ev;
         if (step_events.size() >= 3) return;
         ev.kind = kind;
         ev.tok = tok;
         ev.text = text;
         ev.nest = opens[6:0];
         ev.code = code;
         ev.last = 1'b0;
         step_events.push_back(ev);
      endfunction

      function void fault(logic [3:0] code);
         emit(EV_FAULT, 4'd0, 8'd0, code);
         faulted = 1;
      endfunction

      function bit blank(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
      endfunction

      function bit digit(logic [7:0] c);
         return c >= CH_0 && c <= CH_9;
      endfunction

      function void open_box(bit is_arr);
         if (opens < NestCap) begin
            kinds[opens] = is_arr;
            opens++;
         end
         emit(EV_TOKEN, is_arr ? TK_ARR_OPEN : TK_OBJ_OPEN, 8'd0, 4'd0);
         mode = is_arr ? M_ARR_FIRST : M_OBJ_FIRST;
      endfunction

      function void close_box();
         bit is_arr;
         is_arr = 0;
         if (opens > 0) begin
            opens--;
            is_arr = kinds[opens];
         end
         emit(EV_TOKEN, is_arr ? TK_ARR_CLOSE : TK_OBJ_CLOSE, 8'd0, 4'd0);
         mode = M_AFTER;
      endfunction

      function void end_number();
         emit(EV_TOKEN, has_point ? TK_FRAC : TK_INT, 8'd0, 4'd0);
         mode = M_AFTER;
      endfunction

      function void string_char(logic [7:0] c, bit is_key);
         if (esc) begin
            esc = 0;
            case (c)
               CH_QUOTE, CH_SLASH, CH_BSLASH: emit(EV_TEXT, 4'd0, c, 4'd0);
               CH_LO_B: emit(EV_TEXT, 4'd0, 8'd8, 4'd0);
               CH_LO_F: emit(EV_TEXT, 4'd0, 8'd12, 4'd0);
               CH_LO_N: emit(EV_TEXT, 4'd0, CH_LF, 4'd0);
               CH_LO_R: emit(EV_TEXT, 4'd0, CH_CR, 4'd0);
               CH_LO_T: emit(EV_TEXT, 4'd0, CH_TAB, 4'd0);
               CH_LO_U: ;
               default: fault(FC_BAD_ESCAPE);
            endcase
         end else if (c == CH_BSLASH) begin
            esc = 1;
         end else if (c == CH_QUOTE) begin
            emit(EV_TOKEN, is_key ? TK_KEY : TK_STRING, 8'd0, 4'd0);
            mode = is_key ? M_COLON : M_AFTER;
         end else if (c == CH_LF || c == CH_CR) begin
            fault(FC_RAW_NEWLINE);
         end else begin
            emit(EV_TEXT, 4'd0, c, 4'd0);
         end
      endfunction

      // Return 1 when the byte must be handled again in the new mode.
      function bit take(logic [7:0] c);
         int lim;
         case (mode)
            M_VALUE: begin
               lim = limit_reg > NestCap ? NestCap : limit_reg;
               if (opens + 1 > lim) begin
                  fault(FC_TOO_DEEP);
                  return 0;
               end
               if (blank(c)) return 0;
               if (c == CH_LBRACE) open_box(0);
               else if (c == CH_LBRACK) open_box(1);
               else if (c == CH_QUOTE) begin
                  mode = M_STRING;
                  esc = 0;
               end else if (digit(c)) begin
                  mode = M_NUMBER;
                  num_phase = 0;
                  has_point = 0;
               end else if (c == CH_LO_T || c == CH_LO_F || c == CH_LO_N) begin
                  mode = M_LIT;
                  lit_pos = 0;
                  lit_idx = c == CH_LO_T ? 0 : c == CH_LO_F ? 1 : 2;
               end else if (c == CH_RBRACE || c == CH_RBRACK || c == CH_COMMA ||
                            c == CH_COLON || c == CH_NUL) fault(FC_VALUE_EXP);
               else fault(FC_BAD_TOKEN);
               return 0;
            end
            M_ARR_FIRST: begin
               if (blank(c)) return 0;
               if (c == CH_RBRACK) begin
                  close_box();
                  return 0;
               end
               mode = M_VALUE;
               return 1;
            end
            M_OBJ_FIRST: begin
               if (c == CH_RBRACE) begin
                  close_box();
                  return 0;
               end
               mode = M_KEY;
               return 1;
            end
            M_KEY: begin
               if (blank(c)) return 0;
               if (c == CH_QUOTE) begin
                  mode = M_KEYSTR;
                  esc = 0;
               end else fault(FC_BAD_KEY);
               return 0;
            end
            M_KEYSTR: begin
               string_char(c, 1);
               return 0;
            end
            M_STRING: begin
               string_char(c, 0);
               return 0;
            end
            M_COLON: begin
               if (blank(c)) return 0;
               if (c == CH_COLON) mode = M_VALUE;
               else fault(FC_NO_COLON);
               return 0;
            end
            M_NUMBER: begin
               if (digit(c)) begin
                  if (num_phase == 2) num_phase = 3;
                  return 0;
               end
               if (num_phase == 0 && c == CH_POINT) begin
                  has_point = 1;
                  num_phase = 1;
                  return 0;
               end
               if (num_phase <= 1 && (c == CH_LO_E || c == CH_UP_E)) begin
                  num_phase = 2;
                  return 0;
               end
               if (num_phase == 2 && (c == CH_PLUS || c == CH_MINUS)) begin
                  num_phase = 3;
                  return 0;
               end
               end_number();
               return 1;
            end
            M_LIT: begin
               if (lit_pos >= lit_words[lit_idx].len() ||
                   c != lit_words[lit_idx][lit_pos]) begin
                  fault(FC_BAD_TOKEN);
                  return 0;
               end
               lit_pos++;
               if (lit_pos == lit_words[lit_idx].len()) begin
                  lit_pos = 0;
                  emit(EV_TOKEN, TK_TRUE + 4'(lit_idx), 8'd0, 4'd0);
                  mode = M_AFTER;
               end
               return 0;
            end
            default: begin
               if (opens == 0) begin
                  fault(FC_TRAILING);
                  return 0;
               end
               if (blank(c)) return 0;
               if (kinds[opens - 1]) begin
                  if (c == CH_COMMA) mode = M_VALUE;
                  else if (c == CH_RBRACK) close_box();
                  else fault(FC_NO_COMMA_BK);
               end else begin
                  if (c == CH_COMMA) mode = M_KEY;
                  else if (c == CH_RBRACE) close_box();
                  else fault(FC_NO_COMMA_BR);
               end
               return 0;
            end
         endcase
      endfunction

      function void note_input(logic [7:0] c, logic eod);
         step_events.delete();
         if (!faulted) begin
            for (int pass = 0; pass < 3; pass++) begin
               if (!take(c) || faulted) break;
            end
         end
         if (eod) begin
            if (!faulted) begin
               if (mode == M_NUMBER) end_number();
               if (mode == M_AFTER && opens == 0) emit(EV_ACCEPT, 4'd0, 8'd0, 4'd0);
               else fault(FC_EARLY_END);
            end
            clear_doc();
         end
         if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
         foreach (step_events[i]) events_due.push_back(step_events[i]);
      endfunction

      function void report(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(event_type got);
         event_type want;
         if (events_due.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = events_due.pop_front();
         events_checked++;
         report("event_kind", want.kind, got.kind);
         report("token_kind", want.tok, got.tok);
         report("text_byte", want.text, got.text);
         report("nest_level", want.nest, got.nest);
         report("fault_code", want.code, got.code);
         report("last_of_run", want.last, got.last);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_data_byte;
   logic       req_end_of_doc;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_event_kind;
   logic [3:0] rsp_token_kind;
   logic [7:0] rsp_text_byte;
   logic [6:0] rsp_nest_level;
   logic [3:0] rsp_fault_code;
   logic       rsp_last_of_run;

   doc_scoreboard sb = new();
   logic [7:0] doc_bytes[$];
   int  bytes_sent = 0;
   int  docs_sent = 0;
   bit  calm = 0;
   int  hold_asks = 0;
   int  hold_done = 0;
   int  hold_left = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;

   json_stream_syntax_checker uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_end_of_doc(req_end_of_doc),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_kind(rsp_event_kind),
      .rsp_token_kind(rsp_token_kind),
      .rsp_text_byte(rsp_text_byte),
      .rsp_nest_level(rsp_nest_level),
      .rsp_fault_code(rsp_fault_code),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial clock = 0;
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      event_type got;
      int r;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = rsp_event_kind;
         got.tok = rsp_token_kind;
         got.text = rsp_text_byte;
         got.nest = rsp_nest_level;
         got.code = rsp_fault_code;
         got.last = rsp_last_of_run;
         sb.check_result(got);
      end
      if (hold_asks != hold_done) begin
         hold_done = hold_asks;
         hold_left = 80;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            rsp_stall <= 1'b0;
         end else if (r < 95) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(8, 30);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 3000) begin
         $display("%0t: watchdog expired with %0d events outstanding", $time, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_byte(logic [7:0] b, logic eod);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_doc <= eod;
      do @(posedge clock); while (req_stall);
      sb.note_input(b, eod);
      bytes_sent++;
   endtask

   task automatic send_doc();
      foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
      docs_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic set_limit(logic [6:0] v);
      drain();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.limit_reg = v;
   endtask

   task automatic run_text(string s);
      doc_bytes.delete();
      for (int i = 0; i < s.len(); i++) doc_bytes.push_back(s[i]);
      send_doc();
   endtask

   function automatic void put_ws();
      logic [7:0] ws[4];
      ws = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
      if ($urandom_range(0, 9) < 3)
         repeat ($urandom_range(1, 2)) doc_bytes.push_back(ws[$urandom_range(0, 3)]);
   endfunction

   function automatic void put_digits();
      repeat ($urandom_range(1, 3)) doc_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void put_string();
      string esc_set;
      string hex_set;
      logic [7:0] c;
      esc_set = "\"/\\bfnrtu";
      hex_set = "0123456789abcdefABCDEF";
      doc_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
         case ($urandom_range(0, 5))
            0: doc_bytes.push_back(8'($urandom_range(128, 255)));
            1: begin
               c = esc_set[$urandom_range(0, esc_set.len() - 1)];
               doc_bytes.push_back(CH_BSLASH);
               doc_bytes.push_back(c);
               if (c == CH_LO_U)
                  repeat (4) doc_bytes.push_back(hex_set[$urandom_range(0, hex_set.len() - 1)]);
            end
            default: begin
               do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE || c == CH_BSLASH);
               doc_bytes.push_back(c);
            end
         endcase
      end
      doc_bytes.push_back(CH_QUOTE);
   endfunction

   function automatic void put_value(int lvl, int max_lvl);
      int k;
      int n;
      string w;
      k = lvl >= max_lvl ? $urandom_range(2, 5) : $urandom_range(0, 5);
      case (k)
         0: begin
            doc_bytes.push_back(CH_LBRACE);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) doc_bytes.push_back(CH_COMMA);
               put_ws();
               put_string();
               put_ws();
               doc_bytes.push_back(CH_COLON);
               put_ws();
               put_value(lvl + 1, max_lvl);
               put_ws();
            end
            doc_bytes.push_back(CH_RBRACE);
         end
         1: begin
            doc_bytes.push_back(CH_LBRACK);
            put_ws();
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) doc_bytes.push_back(CH_COMMA);
               put_ws();
               put_value(lvl + 1, max_lvl);
               put_ws();
            end
            doc_bytes.push_back(CH_RBRACK);
         end
         2: put_string();
         3, 4: begin
            put_digits();
            if ($urandom_range(0, 1)) begin
               doc_bytes.push_back(CH_POINT);
               if ($urandom_range(0, 3) != 0) put_digits();
            end
            if ($urandom_range(0, 2) == 0) begin
               doc_bytes.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
               case ($urandom_range(0, 2))
                  0: doc_bytes.push_back(CH_PLUS);
                  1: doc_bytes.push_back(CH_MINUS);
                  default: ;
               endcase
               if ($urandom_range(0, 3) != 0) put_digits();
            end
         end
         default: begin
            case ($urandom_range(0, 2))
               0: w = "true";
               1: w = "false";
               default: w = "nil";
            endcase
            for (int i = 0; i < w.len(); i++) doc_bytes.push_back(w[i]);
         end
      endcase
   endfunction

   function automatic void make_doc();
      int pos;
      doc_bytes.delete();
      put_ws();
      put_value(0, $urandom_range(1, 4));
      case ($urandom_range(0, 9))
         0: begin
            pos = $urandom_range(0, doc_bytes.size() - 1);
            doc_bytes[pos] = 8'($urandom_range(0, 255));
         end
         1: begin
            pos = $urandom_range(1, doc_bytes.size());
            while (doc_bytes.size() > pos) void'(doc_bytes.pop_back());
         end
         2: doc_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
         3: begin
            doc_bytes.delete();
            repeat ($urandom_range(1, 6)) doc_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
   endfunction

   initial begin
      logic [6:0] lim;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_end_of_doc = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_text("nil");
      run_text("{}");
      run_text("{ }");
      run_text("[9e]");
      run_text("\"\\q\"");
      run_text("\"\n\"");
      run_text("\"\\u1\"");
      run_text("1 ");
      run_text(" ");
      doc_bytes = '{CH_NUL};
      send_doc();

      set_limit(7'd1);
      run_text("[1]");
      run_text("7");
      set_limit(7'd0);
      run_text("x");
      set_limit(7'd127);
      doc_bytes.delete();
      repeat (65) doc_bytes.push_back(CH_LBRACK);
      send_doc();
      set_limit(7'd64);
      doc_bytes.delete();
      repeat (63) doc_bytes.push_back(CH_LBRACK);
      doc_bytes.push_back(CH_0);
      repeat (63) doc_bytes.push_back(CH_RBRACK);
      send_doc();

      for (int ph = 0; bytes_sent < 430; ph++) begin
         case ($urandom_range(0, 7))
            0: lim = 7'd1;
            1: lim = 7'd2;
            2: lim = 7'd3;
            3: lim = 7'd127;
            4: lim = 7'($urandom_range(0, 127));
            default: lim = 7'd64;
         endcase
         set_limit(lim);
         calm = ph % 4 == 1;
         if (ph == 0) begin
            calm = 1;
            hold_asks++;
         end
         repeat ($urandom_range(4, 8)) begin
            make_doc();
            send_doc();
            if ($urandom_range(0, 5) == 0) drain();
         end
      end
      calm = 0;

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d bytes in %0d documents; checked %0d events across depth limits",
               bytes_sent, docs_sent, sb.events_checked);
      $display("Covered token, text, fault and accept events with random idling and stalls");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

FILE: sim.f
design/jssc_pkg.sv
design/json_stream_syntax_checker.sv
design/jssc_checker.sv
dv/tb.sv
